// ===== sv/centroid_vehicle_tracker_defines.svh =====
// Assertion macros shared by the vehicle tracker RTL.
`ifndef CENTROID_VEHICLE_TRACKER_DEFINES_SVH
`define CENTROID_VEHICLE_TRACKER_DEFINES_SVH
`ifndef SYNTH
// Same-cycle implication, sampled on clk and disabled during reset.
`define CVT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");
// Next-cycle implication, sampled on clk and disabled during reset.
`define CVT_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define CVT_ASSERT_IMP(lbl, ante, cons)
`define CVT_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ===== sv/cvt_pkg.sv =====
// Types, constants and codes of the centroid vehicle tracker.
`default_nettype none
package cvt_pkg;

  // Table size and coordinate width of the box fields that take part.
  localparam int MAX_TRACKS = 16;
  localparam int COORD_BITS = 12;
  localparam int CNT_W      = $clog2(MAX_TRACKS + 1);

  localparam logic [11:0] COORD_MASK = 12'((33'd1 << COORD_BITS) - 33'd1);

  localparam logic [1:0] WARMUP_FRAMES = 2'd2;
  localparam logic [1:0] FRAMES_SAT    = 2'd3;
  localparam logic [15:0] OBJ_SAT      = 16'hFFFF;

  localparam logic [8:0] MIN_WIDTH_RST  = 9'd120;
  localparam logic [7:0] MIN_HEIGHT_RST = 8'd50;

  // Configuration port decode.
  localparam int ADDR_W = 3;
  localparam logic REG_MIN_WIDTH  = 1'b0;
  localparam logic REG_MIN_HEIGHT = 1'b1;

  typedef enum logic [1:0] {
    REQ_BOX       = 2'd0,
    REQ_EOF       = 2'd1,
    REQ_CLR_TOTAL = 2'd2
  } req_type_t;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [11:0] box_x;
    logic [11:0] box_y;
    logic [11:0] box_w;
    logic [11:0] box_h;
  } in_data_t;

  typedef struct packed {
    logic        qualified;
    logic        is_new;
    logic [4:0]  matched_tracks;
    logic [12:0] center_x;
    logic [12:0] center_y;
    logic [15:0] frame_objects;
    logic [31:0] total_count;
    logic        table_full;
  } out_data_t;

  typedef struct packed {
    logic [8:0] min_width;
    logic [7:0] min_height;
  } cfg_t;

  // Command from the control stage to the track table.
  typedef struct packed {
    logic        track;
    logic        clear;
    logic [12:0] cx;
    logic [12:0] cy;
  } trk_cmd_t;

  // Lookup result of the track table for the current centre.
  typedef struct packed {
    logic [CNT_W-1:0] hit_cnt;
    logic             any_hit;
    logic             full;
  } trk_res_t;

endpackage
`default_nettype wire

// ===== sv/cvt_cfg_regs.sv =====
// Configuration registers behind the APB-style port.
`default_nettype none
module cvt_cfg_regs (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic [cvt_pkg::ADDR_W-1:0] paddr,
  input  wire logic [31:0]               pwdata,
  output logic      [31:0]               prdata,
  output logic                           pready,
  output cvt_pkg::cfg_t                  cfg
);
  import cvt_pkg::*;

  logic [8:0] min_width_r;
  logic [7:0] min_height_r;
  logic       wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  // Register writes at the access phase.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_width_r  <= MIN_WIDTH_RST;
      min_height_r <= MIN_HEIGHT_RST;
    end else if (wr_en) begin
      case (paddr[2])
        REG_MIN_WIDTH:  min_width_r  <= pwdata[8:0];
        REG_MIN_HEIGHT: min_height_r <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // Read data mux.
  always_comb begin
    case (paddr[2])
      REG_MIN_WIDTH:  prdata = {23'd0, min_width_r};
      REG_MIN_HEIGHT: prdata = {24'd0, min_height_r};
      default:        prdata = 32'd0;
    endcase
  end

  assign cfg.min_width  = min_width_r;
  assign cfg.min_height = min_height_r;

endmodule
`default_nettype wire

// ===== sv/cvt_track_table.sv =====
// Track table: stored centres, parallel window compare and update.
`default_nettype none
`include "centroid_vehicle_tracker_defines.svh"
module cvt_track_table (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire cvt_pkg::cfg_t    cfg,
  input  wire cvt_pkg::trk_cmd_t cmd,
  output cvt_pkg::trk_res_t     res
);
  import cvt_pkg::*;

  logic [12:0]           track_cx_r [MAX_TRACKS];
  logic [12:0]           track_cy_r [MAX_TRACKS];
  logic [MAX_TRACKS-1:0] valid_r;
  logic [CNT_W-1:0]      fill_r;
  logic [MAX_TRACKS-1:0] hit;
  logic [7:0]            half_w;
  logic [6:0]            half_h;
  logic                  full;
  logic                  append;

  assign half_w = cfg.min_width[8:1];
  assign half_h = cfg.min_height[7:1];

  // Every valid entry is compared against the new centre at once.
  always_comb begin
    logic [12:0] dx;
    logic [12:0] dy;
    for (int i = 0; i < MAX_TRACKS; i++) begin
      dx = (cmd.cx >= track_cx_r[i]) ? cmd.cx - track_cx_r[i] : track_cx_r[i] - cmd.cx;
      dy = (cmd.cy >= track_cy_r[i]) ? cmd.cy - track_cy_r[i] : track_cy_r[i] - cmd.cy;
      hit[i] = valid_r[i] && (dx < {5'd0, half_w}) && (dy < {6'd0, half_h});
    end
  end

  assign full   = (fill_r == CNT_W'(MAX_TRACKS));
  assign append = cmd.track && !(|hit) && !full;

  assign res.hit_cnt = CNT_W'($countones(hit));
  assign res.any_hit = |hit;
  assign res.full    = full;

  // Centre storage: matching entries take the new centre, or one entry is appended.
  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_TRACKS; i++) begin
      if (cmd.track && (hit[i] || (append && fill_r == CNT_W'(i)))) begin
        track_cx_r[i] <= cmd.cx;
        track_cy_r[i] <= cmd.cy;
      end
    end
  end

  // Valid bits and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      fill_r  <= '0;
    end else if (cmd.clear) begin
      valid_r <= '0;
      fill_r  <= '0;
    end else if (append) begin
      for (int i = 0; i < MAX_TRACKS; i++) begin
        if (fill_r == CNT_W'(i)) begin
          valid_r[i] <= 1'b1;
        end
      end
      fill_r <= fill_r + CNT_W'(1);
    end
  end

  `CVT_ASSERT_IMP(a_fill_bound, 1'b1, fill_r <= CNT_W'(MAX_TRACKS))
  `CVT_ASSERT_IMP(a_fill_matches_valid, 1'b1, $countones(valid_r) == int'(fill_r))
  `CVT_ASSERT_NXT(a_clear_empties, cmd.clear, fill_r == '0 && valid_r == '0)

endmodule
`default_nettype wire

// ===== sv/centroid_vehicle_tracker.sv =====
// Top level of the centroid vehicle tracker: input stage, counters, result stage.
//
//  Channel  Ports                           Moves
//  in       in_valid, in_ready, in_data     one request: box, end of frame, clear total
//  out      out_valid, out_ready, out_data  one status result per request
//  cfg      psel .. pready                  min_width at 0x0, min_height at 0x4
//
// A request accepted into the input register goes through one pass of combinational
// work (centre, window compare against all tracks, counters) and lands in the result
// register once that register is free; while the output is not stalled, one request per
// cycle is sustained. The sixteen-way track compare sets the cycle.
// Reset is synchronous; no clearing pass is needed, the tracks are usable at once.
// A stalled result holds the result register and the input register takes one more.
`default_nettype none
`include "centroid_vehicle_tracker_defines.svh"
module centroid_vehicle_tracker (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire cvt_pkg::in_data_t         in_data,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output cvt_pkg::out_data_t             out_data,
  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic [cvt_pkg::ADDR_W-1:0] paddr,
  input  wire logic [31:0]               pwdata,
  output logic      [31:0]               prdata,
  output logic                           pready
);
  import cvt_pkg::*;

  cfg_t      cfg;
  trk_cmd_t  trk_cmd;
  trk_res_t  trk_res;

  in_data_t  in_r;
  logic      in_valid_r;
  out_data_t out_r, out_nxt;
  logic      out_valid_r;
  logic      advance;

  logic [31:0] total_r, total_nxt;
  logic [15:0] objects_r, objects_nxt;
  logic [1:0]  frames_r, frames_nxt;
  logic        anyq_r, anyq_nxt;

  logic [11:0] bx, by, bw, bh;
  logic [12:0] cx, cy;
  logic        is_box, qual, warm, track_en, clear_en;
  logic [15:0] obj_inc;

  cvt_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Pipeline handshake: the work stage moves when the result register is free.
  assign advance  = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_r <= in_data;
    end
  end

  // Box centre and qualification.
  assign is_box   = (in_r.req_type == REQ_BOX);
  assign bx       = in_r.box_x & COORD_MASK;
  assign by       = in_r.box_y & COORD_MASK;
  assign bw       = in_r.box_w & COORD_MASK;
  assign bh       = in_r.box_h & COORD_MASK;
  assign cx       = {1'b0, bx} + {2'b0, bw[11:1]};
  assign cy       = {1'b0, by} + {2'b0, bh[11:1]};
  assign qual     = is_box && ({3'd0, bw} > {3'd0, cfg.min_width}) &&
                    ({4'd0, bh} > {4'd0, cfg.min_height});
  assign warm     = (frames_r < WARMUP_FRAMES);
  assign track_en = advance && qual && !warm;
  assign clear_en = advance && (in_r.req_type == REQ_EOF) && !anyq_r;
  assign obj_inc  = (objects_r < OBJ_SAT) ? objects_r + 16'd1 : objects_r;

  assign trk_cmd.track = track_en;
  assign trk_cmd.clear = clear_en;
  assign trk_cmd.cx    = cx;
  assign trk_cmd.cy    = cy;

  cvt_track_table u_table (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg),
    .cmd   (trk_cmd),
    .res   (trk_res)
  );

  // Counter updates and the result word for the request in the work stage.
  always_comb begin
    total_nxt   = total_r;
    objects_nxt = objects_r;
    frames_nxt  = frames_r;
    anyq_nxt    = anyq_r;
    out_nxt     = '0;
    out_nxt.frame_objects = objects_r;
    case (in_r.req_type)
      REQ_BOX: begin
        out_nxt.center_x = cx;
        out_nxt.center_y = cy;
        if (qual) begin
          anyq_nxt    = 1'b1;
          objects_nxt = obj_inc;
          out_nxt.qualified     = 1'b1;
          out_nxt.frame_objects = obj_inc;
          if (warm) begin
            total_nxt = 32'd0;
          end else if (!trk_res.any_hit) begin
            total_nxt          = total_r + 32'd1;
            out_nxt.is_new     = 1'b1;
            out_nxt.table_full = trk_res.full;
          end else begin
            out_nxt.matched_tracks = 5'(trk_res.hit_cnt);
          end
        end
      end
      REQ_EOF: begin
        objects_nxt = 16'd0;
        anyq_nxt    = 1'b0;
        if (frames_r < FRAMES_SAT) begin
          frames_nxt = frames_r + 2'd1;
        end
      end
      REQ_CLR_TOTAL: begin
        total_nxt = 32'd0;
      end
      default: ;
    endcase
    out_nxt.total_count = total_nxt;
  end

  // Frame and vehicle counters.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r   <= 32'd0;
      objects_r <= 16'd0;
      frames_r  <= 2'd0;
      anyq_r    <= 1'b0;
    end else if (advance) begin
      total_r   <= total_nxt;
      objects_r <= objects_nxt;
      frames_r  <= frames_nxt;
      anyq_r    <= anyq_nxt;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `CVT_ASSERT_NXT(a_eof_keeps_total, advance && in_r.req_type == REQ_EOF, $stable(total_r))
  `CVT_ASSERT_NXT(a_new_counts_one, track_en && !trk_res.any_hit,
    total_r == $past(total_r) + 32'd1)
  `CVT_ASSERT_NXT(a_frames_saturate, frames_r == FRAMES_SAT, frames_r == FRAMES_SAT)

endmodule
`default_nettype wire
